// ===== hdl/aspg_pkg.sv =====
`default_nettype none
package aspg_pkg;

  localparam int MAX_ELEMENTS = 8;
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int VAL_W = $clog2(MAX_ELEMENTS + 1);
  // counter runs one past the length during the search
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 2);

  localparam int CFG_W = 4;
  localparam int OUT_VAL_W = 4;
  localparam int OUT_POS_W = 3;

  typedef struct packed {
    logic             dir;   // 0 faces position 0, 1 faces the far end
    logic [VAL_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] pos;
    entry_t            best;
    entry_t            nb;
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/aspg_store.sv =====
`default_nettype none
module aspg_store (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          clear,
  input  wire  [aspg_pkg::ADDR_W-1:0]  rd_addr,
  input  wire                          wr_en,
  input  wire  [aspg_pkg::ADDR_W-1:0]  wr_addr,
  input  aspg_pkg::entry_t             wr_data,
  output aspg_pkg::entry_t             rd_data
);

  aspg_pkg::entry_t                     mem [aspg_pkg::MAX_ELEMENTS];
  logic [aspg_pkg::MAX_ELEMENTS-1:0]    valid_r;
  aspg_pkg::entry_t                     rd_q_r;
  logic                                 rd_vld_r;
  logic [aspg_pkg::ADDR_W-1:0]          rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r    <= mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  // an entry never written since reset, restart or length change reads as identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
      if (clear) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (rd_vld_r) begin
      rd_data = rd_q_r;
    end else begin
      rd_data.dir = 1'b0;
      rd_data.val = aspg_pkg::VAL_W'(rd_addr_r) + aspg_pkg::VAL_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/aspg_scan.sv =====
`default_nettype none
module aspg_scan (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire                          active,
  input  wire  [aspg_pkg::CNT_W-1:0]   cnt,
  input  wire  [aspg_pkg::CNT_W-1:0]   n,
  input  aspg_pkg::entry_t             rd_data,
  output aspg_pkg::step_t              result
);

  aspg_pkg::entry_t               cur_r;
  aspg_pkg::entry_t               prev_r;
  aspg_pkg::entry_t               best_r;
  aspg_pkg::entry_t               nb_r;
  logic                           found_r;
  logic [aspg_pkg::ADDR_W-1:0]    pos_r;

  logic                           data_in;
  logic                           eval;
  logic                           has_left;
  logic                           has_right;
  logic                           mobile;
  logic                           take;
  logic [aspg_pkg::CNT_W-1:0]     eval_pos;

  // cur_r holds position cnt-2, prev_r cnt-3, rd_data cnt-1
  always_comb begin
    data_in   = active && (cnt >= aspg_pkg::CNT_W'(1)) && (cnt <= n);
    eval      = active && (cnt >= aspg_pkg::CNT_W'(2));
    has_left  = cnt >= aspg_pkg::CNT_W'(3);
    has_right = cnt <= n;
    eval_pos  = cnt - aspg_pkg::CNT_W'(2);
    if (cur_r.dir) begin
      mobile = has_right && (cur_r.val > rd_data.val);
    end else begin
      mobile = has_left && (cur_r.val > prev_r.val);
    end
    take = eval && mobile && (!found_r || (cur_r.val > best_r.val));
  end

  always_ff @(posedge clk) begin
    if (data_in) begin
      prev_r <= cur_r;
      cur_r  <= rd_data;
    end
    if (take) begin
      best_r <= cur_r;
      nb_r   <= cur_r.dir ? rd_data : prev_r;
      pos_r  <= aspg_pkg::ADDR_W'(eval_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (start) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  assign result.found = found_r;
  assign result.pos   = pos_r;
  assign result.best  = best_r;
  assign result.nb    = nb_r;

endmodule
`default_nettype wire

// ===== hdl/aspg_emit.sv =====
`default_nettype none
module aspg_emit (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                active,
  input  wire  [aspg_pkg::ADDR_W-1:0]        pos,
  input  wire  [aspg_pkg::CNT_W-1:0]         n,
  input  aspg_pkg::entry_t                   rd_data,
  input  aspg_pkg::step_t                    step,
  input  wire                                swap_en,
  input  wire                                exh,
  output logic                               wr_en,
  output logic [aspg_pkg::ADDR_W-1:0]        wr_addr,
  output aspg_pkg::entry_t                   wr_data,
  output logic                               out_valid,
  output logic [aspg_pkg::OUT_VAL_W-1:0]     out_element_value,
  output logic [aspg_pkg::OUT_POS_W-1:0]     out_element_position,
  output logic                               out_last_element,
  output logic                               out_exhausted
);

  logic                                 valid_r;
  logic [aspg_pkg::OUT_VAL_W-1:0]       value_r;
  logic [aspg_pkg::OUT_POS_W-1:0]       position_r;
  logic                                 last_r;
  logic                                 exh_r;

  logic [aspg_pkg::ADDR_W-1:0]          dst;
  aspg_pkg::entry_t                     ent;

  // swap is applied on the way through: the two touched positions take the saved entries
  always_comb begin
    dst = step.best.dir ? step.pos + aspg_pkg::ADDR_W'(1) : step.pos - aspg_pkg::ADDR_W'(1);
    ent = rd_data;
    if (swap_en && (pos == step.pos)) begin
      ent = step.nb;
    end else if (swap_en && (pos == dst)) begin
      ent = step.best;
    end
    if (swap_en && (ent.val > step.best.val)) begin
      ent.dir = ~ent.dir;
    end
  end

  assign wr_en   = active;
  assign wr_addr = pos;
  assign wr_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      value_r    <= aspg_pkg::OUT_VAL_W'(ent.val);
      position_r <= aspg_pkg::OUT_POS_W'(pos);
      last_r     <= (aspg_pkg::CNT_W'(pos) == n - aspg_pkg::CNT_W'(1));
      exh_r      <= exh;
    end
  end

  assign out_valid            = valid_r;
  assign out_element_value    = value_r;
  assign out_element_position = position_r;
  assign out_last_element     = last_r;
  assign out_exhausted        = exh_r;

endmodule
`default_nettype wire

// ===== hdl/adjacent_swap_permutation_generator_unit.sv =====
`default_nettype none
// channel   ports                                                  transfer
// -------   -----------------------------------------------------  -----------------------
// input     start, busy, in_restart                                start && !busy
// result    out_valid, out_element_value, out_element_position,    every out_valid cycle
//           out_last_element, out_exhausted
// config    cfg_valid, cfg_ready, cfg_data                         cfg_valid && cfg_ready
//
// A step item runs a search over the permutation memory, then a pass that reads, swaps,
// flips and writes back each entry; a restart item runs the pass only. Results leave one
// per cycle from the output register and cannot be held off. Reset, a restart and a
// length write reload the identity by clearing per-entry valid bits. cfg_ready is high
// only while the block is idle.
module adjacent_swap_permutation_generator_unit (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire                                in_restart,
  output logic                               out_valid,
  output logic [aspg_pkg::OUT_VAL_W-1:0]     out_element_value,
  output logic [aspg_pkg::OUT_POS_W-1:0]     out_element_position,
  output logic                               out_last_element,
  output logic                               out_exhausted,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [aspg_pkg::CFG_W-1:0]         cfg_data
);

  aspg_pkg::state_t                 state_r, state_nxt;
  logic [aspg_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [aspg_pkg::CNT_W-1:0]       n_r, n_nxt;
  logic                             restart_r, restart_nxt;

  logic                             accept;
  logic                             cfg_wr;
  logic                             clear;
  logic                             scan_start;
  logic                             emit_act;
  logic [aspg_pkg::CNT_W-1:0]       n_sat;

  aspg_pkg::entry_t                 rd_data;
  aspg_pkg::entry_t                 wr_data;
  logic                             wr_en;
  logic [aspg_pkg::ADDR_W-1:0]      wr_addr;
  aspg_pkg::step_t                  step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= aspg_pkg::ST_IDLE;
      cnt_r     <= '0;
      n_r       <= aspg_pkg::CNT_W'(aspg_pkg::MAX_ELEMENTS);
      restart_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      n_r       <= n_nxt;
      restart_r <= restart_nxt;
    end
  end

  always_comb begin
    if (cfg_data < aspg_pkg::CFG_W'(2)) begin
      n_sat = aspg_pkg::CNT_W'(2);
    end else if (32'(cfg_data) > aspg_pkg::MAX_ELEMENTS) begin
      n_sat = aspg_pkg::CNT_W'(aspg_pkg::MAX_ELEMENTS);
    end else begin
      n_sat = aspg_pkg::CNT_W'(cfg_data);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r + aspg_pkg::CNT_W'(1);
    n_nxt       = n_r;
    restart_nxt = restart_r;
    busy        = 1'b1;
    cfg_ready   = 1'b0;
    accept      = 1'b0;
    cfg_wr      = 1'b0;
    scan_start  = 1'b0;
    emit_act    = 1'b0;
    unique case (state_r)
      aspg_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cfg_ready = 1'b1;
        cnt_nxt   = '0;
        cfg_wr    = cfg_valid;
        if (cfg_valid) begin
          n_nxt = n_sat;
        end
        accept = start;
        if (start) begin
          restart_nxt = in_restart;
          scan_start  = !in_restart;
          state_nxt   = in_restart ? aspg_pkg::ST_EMIT : aspg_pkg::ST_SCAN;
        end
      end
      aspg_pkg::ST_SCAN: begin
        if (cnt_r == n_r + aspg_pkg::CNT_W'(1)) begin
          cnt_nxt   = '0;
          state_nxt = aspg_pkg::ST_EMIT;
        end
      end
      aspg_pkg::ST_EMIT: begin
        emit_act = cnt_r != '0;
        if (cnt_r == n_r) begin
          state_nxt = aspg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = aspg_pkg::ST_IDLE;
      end
    endcase
  end

  assign clear = cfg_wr || (accept && in_restart);

  aspg_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clear),
    .rd_addr (aspg_pkg::ADDR_W'(cnt_r)),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  aspg_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .active  (state_r == aspg_pkg::ST_SCAN),
    .cnt     (cnt_r),
    .n       (n_r),
    .rd_data (rd_data),
    .result  (step)
  );

  aspg_emit u_emit (
    .clk                  (clk),
    .rst_n                (rst_n),
    .active               (emit_act),
    .pos                  (aspg_pkg::ADDR_W'(cnt_r - aspg_pkg::CNT_W'(1))),
    .n                    (n_r),
    .rd_data              (rd_data),
    .step                 (step),
    .swap_en              (!restart_r && step.found),
    .exh                  (!restart_r && !step.found),
    .wr_en                (wr_en),
    .wr_addr              (wr_addr),
    .wr_data              (wr_data),
    .out_valid            (out_valid),
    .out_element_value    (out_element_value),
    .out_element_position (out_element_position),
    .out_last_element     (out_last_element),
    .out_exhausted        (out_exhausted)
  );

endmodule
`default_nettype wire

// ===== hdl/aspg_checker.sv =====
`default_nettype none
module aspg_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                start,
  input wire                                busy,
  input wire                                out_valid,
  input wire [aspg_pkg::OUT_POS_W-1:0]      out_element_position,
  input wire                                out_last_element,
  input wire                                cfg_ready
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after input transfer");

  a_no_cfg_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready)
    else $error("config ready while busy");

  a_result_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result outside item work");

  a_positions_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_element |=>
      out_valid && (out_element_position == $past(out_element_position) + 3'd1))
    else $error("result sequence broken");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_element |=> !out_valid)
    else $error("result after last element");

endmodule

bind adjacent_swap_permutation_generator_unit aspg_checker u_aspg_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_element_position (out_element_position),
  .out_last_element     (out_last_element),
  .cfg_ready            (cfg_ready)
);
`default_nettype wire

// ===== tb/sv/adjacent_swap_permutation_generator_unit_tb.sv =====
`timescale 1ns / 100ps

module adjacent_swap_permutation_generator_unit_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 2 * aspg_pkg::MAX_ELEMENTS + 8;

  typedef struct {
    logic [aspg_pkg::OUT_VAL_W-1:0] value;
    logic [aspg_pkg::OUT_POS_W-1:0] position;
    logic                           last;
    logic                           exhausted;
  } elem_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           in_restart = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [aspg_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           busy;
  logic                           out_valid;
  logic [aspg_pkg::OUT_VAL_W-1:0] out_element_value;
  logic [aspg_pkg::OUT_POS_W-1:0] out_element_position;
  logic                           out_last_element;
  logic                           out_exhausted;
  logic                           cfg_ready;

  // predictor state: permutation, one direction bit per value (index value-1)
  logic [aspg_pkg::OUT_VAL_W-1:0] perm_q [aspg_pkg::MAX_ELEMENTS];
  logic                           facing_right [aspg_pkg::MAX_ELEMENTS];
  logic [aspg_pkg::CFG_W-1:0]     length_reg;

  elem_t expected_elems [$];
  elem_t got_elem;

  int errors = 0;
  int items_sent = 0;
  int restarts_sent = 0;
  int length_writes = 0;
  int elems_checked = 0;
  int exhausted_perms = 0;
  int cycle_count = 0;

  adjacent_swap_permutation_generator_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_restart           (in_restart),
    .out_valid            (out_valid),
    .out_element_value    (out_element_value),
    .out_element_position (out_element_position),
    .out_last_element     (out_last_element),
    .out_exhausted        (out_exhausted),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d elements outstanding", $time,
               cycle_count, expected_elems.size());
      $display("adjacent_swap_permutation_generator_unit test failed");
      $finish;
    end
  end

  function automatic int active_len();
    int n;
    n = length_reg;
    if (n < 2) n = 2;
    if (n > aspg_pkg::MAX_ELEMENTS) n = aspg_pkg::MAX_ELEMENTS;
    return n;
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < aspg_pkg::MAX_ELEMENTS; i++) begin
      perm_q[i] = aspg_pkg::OUT_VAL_W'(i + 1);
      facing_right[i] = 1'b0;
    end
  endfunction

  function automatic void queue_permutation(input int n, input logic exh);
    elem_t e;
    for (int i = 0; i < n; i++) begin
      e.value = perm_q[i];
      e.position = aspg_pkg::OUT_POS_W'(i);
      e.last = (i == n - 1);
      e.exhausted = exh;
      expected_elems.push_back(e);
    end
  endfunction

  // one Johnson-Trotter step, or a reload of the identity
  function automatic void predict_permutation(input logic restart);
    int n;
    int best;
    int pos;
    int v;
    logic mobile;
    logic [aspg_pkg::OUT_VAL_W-1:0] tmp;
    n = active_len();
    best = 0;
    pos = 0;
    if (restart) begin
      load_identity();
      queue_permutation(n, 1'b0);
      return;
    end
    for (int i = 0; i < n; i++) begin
      v = perm_q[i];
      if (!facing_right[v-1]) mobile = (i != 0) && (v > perm_q[i-1]);
      else mobile = (i + 1 < n) && (v > perm_q[i+1]);
      if (mobile && v > best) begin
        best = v;
        pos = i;
      end
    end
    if (best == 0) begin
      queue_permutation(n, 1'b1);
      return;
    end
    tmp = perm_q[pos];
    if (!facing_right[best-1]) begin
      perm_q[pos] = perm_q[pos-1];
      perm_q[pos-1] = tmp;
    end else begin
      perm_q[pos] = perm_q[pos+1];
      perm_q[pos+1] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      if (perm_q[i] > best) facing_right[perm_q[i]-1] = !facing_right[perm_q[i]-1];
    end
    queue_permutation(n, 1'b0);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_elems.size() == 0) begin
        errors++;
        $display("%0t: unexpected element value=%0d pos=%0d last=%0b exh=%0b", $time,
                 out_element_value, out_element_position, out_last_element, out_exhausted);
      end else begin
        got_elem = expected_elems.pop_front();
        elems_checked++;
        if (out_last_element && out_exhausted) exhausted_perms++;
        if (out_element_value !== got_elem.value) begin
          errors++;
          $display("%0t: element_value expected %0d got %0d", $time, got_elem.value,
                   out_element_value);
        end
        if (out_element_position !== got_elem.position) begin
          errors++;
          $display("%0t: element_position expected %0d got %0d", $time, got_elem.position,
                   out_element_position);
        end
        if (out_last_element !== got_elem.last) begin
          errors++;
          $display("%0t: last_element expected %0b got %0b", $time, got_elem.last,
                   out_last_element);
        end
        if (out_exhausted !== got_elem.exhausted) begin
          errors++;
          $display("%0t: exhausted expected %0b got %0b", $time, got_elem.exhausted,
                   out_exhausted);
        end
      end
    end
  end

  // start stays high across back-to-back items; only a gap or a drain lowers it
  task automatic send_item(input logic restart);
    start <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (busy);
    predict_permutation(restart);
    items_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [aspg_pkg::CFG_W-1:0] len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    length_reg = len;
    load_identity();
    length_writes++;
  endtask

  task automatic test_reset_defaults();
    // n = 8 out of reset, identity already loaded
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
  endtask

  task automatic test_exhaustion();
    // n = 2 via saturation of 0: two perms, then exhausted twice
    write_length('0);
    repeat (3) send_item(1'b0);
    send_item(1'b1);
    // n = 3: five steps cover all six perms, the sixth step finds nothing mobile
    write_length(aspg_pkg::CFG_W'(3));
    repeat (6) send_item(1'b0);
  endtask

  task automatic test_length_writes();
    // a write reloads the identity without a restart
    write_length(aspg_pkg::CFG_W'(1));
    send_item(1'b0);
    write_length('1);
    send_item(1'b1);
    send_item(1'b0);
    write_length(aspg_pkg::CFG_W'(9));
    send_item(1'b0);
    write_length(aspg_pkg::CFG_W'(2));
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
  endtask

  // runs of steps mostly from a fresh identity, small n so exhaustion is reached
  task automatic test_random_walk(input int idle_pct, input int quota);
    int done;
    int run_len;
    logic [aspg_pkg::CFG_W-1:0] len;
    done = 0;
    while (done < quota) begin
      case ($urandom_range(7))
        0: len = aspg_pkg::CFG_W'($urandom_range(15));
        1: len = aspg_pkg::CFG_W'(aspg_pkg::MAX_ELEMENTS);
        default: len = aspg_pkg::CFG_W'($urandom_range(5, 2));
      endcase
      write_length(len);
      run_len = $urandom_range(35, 15);
      for (int k = 0; k < run_len && done < quota; k++) begin
        sender_gap(idle_pct);
        if (k == 0) send_item(1'($urandom_range(1)));
        else send_item($urandom_range(19) == 0);
        done++;
      end
    end
  endtask

  initial begin
    length_reg = aspg_pkg::CFG_W'(8);
    load_identity();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_exhaustion();
    test_length_writes();
    // the result side has no backpressure, so only the sender idles
    test_random_walk(0, 70);
    test_random_walk(77, 70);
    test_random_walk(28, 70);

    drain_results();
    $display("%0d items sent (%0d restarts) over %0d length writes, %0d elements checked",
             items_sent, restarts_sent, length_writes, elems_checked);
    $display("%0d permutations came back exhausted", exhausted_perms);
    if (errors == 0) begin
      $display("adjacent_swap_permutation_generator_unit test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("adjacent_swap_permutation_generator_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/aspg_pkg.sv
hdl/aspg_store.sv
hdl/aspg_scan.sv
hdl/aspg_emit.sv
hdl/adjacent_swap_permutation_generator_unit.sv
hdl/aspg_checker.sv
tb/sv/adjacent_swap_permutation_generator_unit_tb.sv
